// ===== design/d2f_pkg.sv =====
// Shared types and constants for the decimal text to single float converter.
package d2f_pkg;

    // Character codes used by the parser
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // IEEE-754 single format
    localparam int unsigned FRAC_BITS = 23;
    localparam logic [7:0]  EXP_BIAS  = 8'd127;

    typedef enum logic [3:0] {
        PH_BLANKS = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    // Sign and saturation of a finished number
    typedef struct packed {
        logic neg;
        logic sat;
    } t_num_flags;

endpackage

// ===== design/d2f_ifs.sv =====
// Valid/ready channel interfaces for characters in and float results out.
interface d2f_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface d2f_float_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    logic        overflow;

    modport source (output valid, output float_bits, output overflow, input ready);
    modport sink   (input valid, input float_bits, input overflow, output ready);
endinterface

// ===== design/decimal_text_to_single_float.sv =====
// Top level: decimal text stream in, IEEE-754 single-precision results out.
// Takes one character per cycle with no gaps while ready is high, and a new text
// may start on the cycle right after the previous one's last character. Leading
// blanks are skipped, one sign is taken, digits accumulate (saturating at
// 2^MAG_BITS-1, flagged by overflow) and anything after the first non-digit is
// ignored. The character marked last_char produces one result through three
// registers: one for the finished magnitude, one for its leading-one position,
// and the output register after normalize/round. These three stages drain into
// each other, so up to three results may wait on the output before input stalls.
module decimal_text_to_single_float
    import d2f_pkg::*;
#(
    parameter int MAG_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    d2f_char_if.sink            i_in,
    d2f_float_if.source         o_out
);

    localparam int EW = $clog2(MAG_BITS);

    logic                in_take;
    logic                en1, en2, en3;

    logic [MAG_BITS-1:0] fin_mag;
    t_num_flags          fin_flags;

    logic                r_s1_v;
    logic [MAG_BITS-1:0] r_s1_mag;
    t_num_flags          r_s1_flags;

    logic                r_s2_v;
    logic [MAG_BITS-1:0] r_s2_mag;
    logic [EW-1:0]       r_s2_msb, n_s2_msb;
    t_num_flags          r_s2_flags;

    logic                r_out_v;
    logic [31:0]         r_out_bits, n_out_bits;
    logic                r_out_ovf, n_out_ovf;

    assign en3     = !r_out_v || o_out.ready;
    assign en2     = !r_s2_v || en3;
    assign en1     = !r_s1_v || en2;
    assign i_in.ready = en1;
    assign in_take = i_in.valid && en1;

    d2f_parse #(.MAG_BITS(MAG_BITS)) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_char  (i_in.char_code),
        .i_last  (i_in.last_char),
        .o_mag   (fin_mag),
        .o_flags (fin_flags)
    );

    // Leading-one position of the finished magnitude
    always_comb begin
        n_s2_msb = '0;
        for (int i = 0; i < MAG_BITS; i++) begin
            if (r_s1_mag[i]) begin
                n_s2_msb = EW'(i);
            end
        end
    end

    d2f_round #(.MAG_BITS(MAG_BITS)) u_round (
        .i_mag      (r_s2_mag),
        .i_msb      (r_s2_msb),
        .i_flags    (r_s2_flags),
        .o_bits     (n_out_bits),
        .o_overflow (n_out_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_v <= in_take && i_in.last_char;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (en3) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_mag   <= fin_mag;
            r_s1_flags <= fin_flags;
        end
        if (en2) begin
            r_s2_mag   <= r_s1_mag;
            r_s2_msb   <= n_s2_msb;
            r_s2_flags <= r_s1_flags;
        end
        if (en3) begin
            r_out_bits <= n_out_bits;
            r_out_ovf  <= n_out_ovf;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.float_bits = r_out_bits;
    assign o_out.overflow   = r_out_ovf;

`ifndef NO_ASSERTIONS
    // a final character always enters the conversion pipeline
    a_last_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && i_in.last_char |=> r_s1_v)
        else $error("last character did not load the conversion stage");

    // zero is always positive zero
    a_no_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (r_out_bits[30:0] == 31'd0) |-> !r_out_bits[31])
        else $error("negative zero produced");

    // exponent never beyond what the magnitude width allows
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_bits[30:23] <= 8'(127 + MAG_BITS)))
        else $error("exponent out of range");

    // a saturated result is never zero
    a_ovf_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_ovf |-> (r_out_bits[30:23] != 8'd0))
        else $error("overflow flagged on a zero result");
`endif

endmodule

// ===== design/d2f_parse.sv =====
// Character parser: blank skip, sign, saturating decimal accumulation.
module d2f_parse
    import d2f_pkg::*;
#(
    parameter int MAG_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    output logic [MAG_BITS-1:0] o_mag,
    output t_num_flags          o_flags
);

    localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

    t_phase              r_phase, n_phase;
    logic [MAG_BITS-1:0] r_mag, n_mag;
    logic                r_neg, n_neg;
    logic                r_sat, n_sat;

    logic                is_digit;
    logic                is_blank;
    logic [3:0]          digit;
    logic [MAG_BITS+3:0] prod;
    logic                too_big;
    logic [MAG_BITS-1:0] dig_mag;
    logic                dig_sat;

    always_comb begin
        is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        is_blank = (i_char == CH_SPACE) || (i_char inside {[CH_TAB:CH_CR]});
        digit    = 4'(i_char - CH_ZERO);
        // mag*10 + digit, wide enough to never wrap
        prod     = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                 + {{MAG_BITS{1'b0}}, digit};
        too_big  = r_sat || (prod > {4'b0000, MAG_MAX});
        dig_mag  = too_big ? MAG_MAX : prod[MAG_BITS-1:0];
        dig_sat  = too_big;
    end

    always_comb begin
        n_phase = r_phase;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_sat   = r_sat;
        unique case (r_phase)
            PH_BLANKS: begin
                if (is_blank) begin
                    n_phase = PH_BLANKS;
                end else if (i_char == CH_PLUS || i_char == CH_MINUS) begin
                    n_neg   = (i_char == CH_MINUS);
                    n_phase = PH_SIGN;
                end else if (is_digit) begin
                    n_mag   = dig_mag;
                    n_sat   = dig_sat;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIGN, PH_DIGITS: begin
                if (is_digit) begin
                    n_mag   = dig_mag;
                    n_sat   = dig_sat;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Value of the text including the current character
    assign o_mag         = n_mag;
    assign o_flags.neg   = n_neg;
    assign o_flags.sat   = n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANKS;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_sat   <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                r_phase <= PH_BLANKS;
                r_mag   <= '0;
                r_neg   <= 1'b0;
                r_sat   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_sat   <= n_sat;
            end
        end
    end

endmodule

// ===== design/d2f_round.sv =====
// Normalize, round to nearest even and pack an integer magnitude as a single float.
module d2f_round
    import d2f_pkg::*;
#(
    parameter int MAG_BITS = 31
) (
    input  logic [MAG_BITS-1:0]         i_mag,
    input  logic [$clog2(MAG_BITS)-1:0] i_msb,
    input  t_num_flags                  i_flags,
    output logic [31:0]                 o_bits,
    output logic                        o_overflow
);

    localparam int EW = $clog2(MAG_BITS);
    localparam int XW = MAG_BITS + FRAC_BITS + 3;

    logic [EW-1:0]       shamt;
    logic [MAG_BITS-1:0] norm;
    logic [XW-1:0]       ext;
    logic [22:0]         frac;
    logic                guard;
    logic                sticky;
    logic                round_up;
    logic [23:0]         frac_sum;
    logic [7:0]          exp_field;

    always_comb begin
        shamt    = EW'(MAG_BITS - 1) - i_msb;
        norm     = i_mag << shamt;
        // leading one lands at the top of ext; zeros below keep guard/sticky defined
        ext      = {norm, (FRAC_BITS + 3)'(0)};
        frac     = ext[XW-2 -: 23];
        guard    = ext[XW-25];
        sticky   = |ext[XW-26:0];
        round_up = guard && (sticky || frac[0]);
        frac_sum = {1'b0, frac} + 24'(round_up);
        exp_field = EXP_BIAS + 8'(i_msb) + 8'(frac_sum[23]);
        if (i_mag == '0) begin
            o_bits = '0;
        end else begin
            o_bits = {i_flags.neg, exp_field, frac_sum[22:0]};
        end
        o_overflow = i_flags.sat && (i_mag != '0);
    end

endmodule

// ===== dv/tb_decimal_text_to_single_float.sv =====
// Testbench for decimal_text_to_single_float: random and directed text streams, scoreboard check.
module tb_decimal_text_to_single_float
    import d2f_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAG_W   = 31;
    localparam int LATENCY = 3;
    localparam int ITEMS   = 1650;

    // Blank codes the package does not name
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;

    typedef struct {
        logic [31:0] bits;
        logic        ovf;
    } t_float_res;

    class d2f_scoreboard;
        longint unsigned acc;
        bit              neg;
        bit              sat;
        t_phase          phase;
        t_float_res      expected_q[$];
        int              errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            acc   = 0;
            neg   = 1'b0;
            sat   = 1'b0;
            phase = PH_BLANKS;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Saturating acc*10 + d
        function void add_digit(int unsigned d);
            longint unsigned lim;
            lim = (64'd1 << MAG_W) - 1;
            if (sat || acc > (lim - d) / 10) begin
                acc = lim;
                sat = 1'b1;
            end else begin
                acc = acc * 10 + d;
            end
        endfunction

        function logic [31:0] pack_single(longint unsigned v, bit sign);
            int              e;
            int              sh;
            longint unsigned q;
            longint unsigned rem;
            longint unsigned half;
            logic [7:0]      ex;
            if (v == 0) return 32'd0;
            e = 0;
            while (e < 63 && (v >> (e + 1)) != 0) e++;
            if (e <= int'(FRAC_BITS)) begin
                q = v << (int'(FRAC_BITS) - e);
            end else begin
                sh   = e - int'(FRAC_BITS);
                q    = v >> sh;
                rem  = v & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                // nearest, ties to even; carry out of the mantissa bumps the exponent
                if (rem > half || (rem == half && q[0])) q++;
                if (q == (64'd1 << (FRAC_BITS + 1))) begin
                    q = q >> 1;
                    e++;
                end
            end
            ex = 8'(e) + EXP_BIAS;
            return {sign, ex, q[22:0]};
        endfunction

        function void note_char(logic [7:0] c, logic last);
            bit         dig;
            bit         blank;
            t_float_res r;
            dig   = (c >= CH_ZERO) && (c <= CH_NINE);
            blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            case (phase)
                PH_BLANKS: begin
                    if (blank) begin
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        neg   = (c == CH_MINUS);
                        phase = PH_SIGN;
                    end else if (dig) begin
                        add_digit(c - CH_ZERO);
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (dig) begin
                        add_digit(c - CH_ZERO);
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                default: ;
            endcase
            if (last) begin
                r.bits = pack_single(acc, neg);
                r.ovf  = (acc != 0) ? sat : 1'b0;
                expected_q.push_back(r);
                restart();
            end
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] bits, logic ovf);
            t_float_res r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result bits=%h ovf=%b", bits, ovf));
                return;
            end
            r = expected_q.pop_front();
            if (bits !== r.bits)
                report($sformatf("float_bits got %h, want %h", bits, r.bits));
            if (ovf !== r.ovf)
                report($sformatf("overflow got %b, want %b (bits %h)", ovf, r.ovf, r.bits));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    d2f_char_if  char_ch ();
    d2f_float_if float_ch ();

    decimal_text_to_single_float #(
        .MAG_BITS (MAG_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (float_ch)
    );

    d2f_scoreboard sb;
    logic [7:0]    txt[$];
    bit            tx_quiet;
    bit            rx_quiet;
    int            sent_count;

    logic [7:0] blank_codes[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            char_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        char_ch.valid     = 1'b1;
        char_ch.char_code = c;
        char_ch.last_char = last;
        do @(posedge i_clk); while (!char_ch.ready);
        sb.note_char(c, last);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_txt();
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
        txt.delete();
    endtask

    task automatic take_results();
        int stall;
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 12);
            float_ch.ready = 1'b0;
            repeat (stall) @(negedge i_clk);
            float_ch.ready = 1'b1;
            do @(posedge i_clk); while (!float_ch.valid);
            sb.check_result(float_ch.float_bits, float_ch.overflow);
            @(negedge i_clk);
        end
    endtask

    task automatic drain_outputs();
        char_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endfunction

    function automatic void push_digits(int n);
        repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void push_blanks(int n);
        repeat (n) txt.push_back(blank_codes[$urandom_range(0, 5)]);
    endfunction

    function automatic void build_random_text();
        int kind;
        int sgn;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                // raw noise, any byte
                repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                // sign followed by a second sign, a blank or junk
                push_blanks($urandom_range(0, 2));
                txt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                case ($urandom_range(0, 3))
                    0: txt.push_back(CH_PLUS);
                    1: txt.push_back(CH_MINUS);
                    2: txt.push_back(blank_codes[$urandom_range(0, 5)]);
                    default: txt.push_back(8'($urandom_range(0, 255)));
                endcase
                push_digits($urandom_range(0, 3));
            end
            2: begin
                // right at the saturation boundary
                if ($urandom_range(0, 1)) txt.push_back(CH_MINUS);
                push_str("214748364");
                push_digits($urandom_range(1, 2));
            end
            default: begin
                push_blanks($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
                sgn = $urandom_range(0, 2);
                if (sgn == 1) txt.push_back(CH_PLUS);
                if (sgn == 2) txt.push_back(CH_MINUS);
                push_digits($urandom_range(0, 3) == 0 ? $urandom_range(10, 14)
                                                      : $urandom_range(1, 9));
                if ($urandom_range(0, 3) == 0) begin
                    txt.push_back(8'($urandom_range(0, 255)));
                    push_digits($urandom_range(0, 2));
                end
            end
        endcase
    endfunction

    initial begin
        int n_texts;
        sb                = new();
        char_ch.valid     = 1'b0;
        char_ch.char_code = 8'd0;
        char_ch.last_char = 1'b0;
        float_ch.ready    = 1'b0;
        i_rst_n           = 1'b0;
        tx_quiet          = 1'b0;
        rx_quiet          = 1'b0;
        sent_count        = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        fork
            take_results();
        join_none

        // NUL and a high code alone: no digits
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        // blanks and a sign only
        push_str(" \t-");
        send_txt();
        // negative zero gives positive zero
        push_str("-0");
        send_txt();
        // a second sign ends the number
        push_str("+-5");
        send_txt();
        // anything after the first non-digit is ignored
        push_str("1x2");
        send_txt();
        txt.push_back(CH_CR);
        txt.push_back(CH_LF);
        txt.push_back(CH_VT);
        txt.push_back(CH_FF);
        push_str("9");
        send_txt();
        // 2^24 + 1: tie, rounds to even
        push_str("-16777217");
        send_txt();
        drain_outputs();

        n_texts = 0;
        while (sent_count < ITEMS) begin
            if (n_texts % 30 == 0) begin
                tx_quiet = ($urandom_range(0, 2) == 0);
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
            if (n_texts == 100) drain_outputs();
            build_random_text();
            send_txt();
            n_texts++;
        end
        drain_outputs();

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
